// File: design/plane_projection_coefficients_top_macros.svh
// assertion macros for the plane projection coefficients block
`ifndef PLANE_PROJECTION_COEFFICIENTS_TOP_MACROS_SVH
`define PLANE_PROJECTION_COEFFICIENTS_TOP_MACROS_SVH

// same-cycle implication
`define PPC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define PPC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: design/ppc_pkg.sv
// shared constants and helpers of the plane projection coefficients block
package ppc_pkg;
	localparam int PPC_DATA_WIDTH = 32;
	localparam int PPC_FRAC_BITS = 16;
	localparam int PPC_MUL_CHUNK = 32;

	function automatic int ppc_max(input int a, input int b);
		return (a > b) ? a : b;
	endfunction
endpackage

// File: design/ppc_item_if.sv
// input word channel of the plane projection coefficients block
interface ppc_item_if import ppc_pkg::*; #(
	parameter int DATA_WIDTH = PPC_DATA_WIDTH
);
	logic valid;
	logic ready;
	logic signed [DATA_WIDTH-1:0] first_x;
	logic signed [DATA_WIDTH-1:0] first_y;
	logic signed [DATA_WIDTH-1:0] first_z;
	logic signed [DATA_WIDTH-1:0] second_x;
	logic signed [DATA_WIDTH-1:0] second_y;
	logic signed [DATA_WIDTH-1:0] second_z;
	logic signed [DATA_WIDTH-1:0] point_x;
	logic signed [DATA_WIDTH-1:0] point_y;
	logic signed [DATA_WIDTH-1:0] point_z;

	modport source (
		output valid, first_x, first_y, first_z, second_x, second_y, second_z,
			point_x, point_y, point_z,
		input ready
	);
	modport sink (
		input valid, first_x, first_y, first_z, second_x, second_y, second_z,
			point_x, point_y, point_z,
		output ready
	);
endinterface

// File: design/ppc_result_if.sv
// result word channel of the plane projection coefficients block
interface ppc_result_if import ppc_pkg::*; #(
	parameter int DATA_WIDTH = PPC_DATA_WIDTH
);
	logic valid;
	logic ready;
	logic signed [DATA_WIDTH-1:0] coef_first;
	logic signed [DATA_WIDTH-1:0] coef_second;
	logic signed [DATA_WIDTH-1:0] proj_x;
	logic signed [DATA_WIDTH-1:0] proj_y;
	logic signed [DATA_WIDTH-1:0] proj_z;
	logic degenerate;
	logic overflowed;

	modport source (
		output valid, coef_first, coef_second, proj_x, proj_y, proj_z, degenerate,
			overflowed,
		input ready
	);
	modport sink (
		input valid, coef_first, coef_second, proj_x, proj_y, proj_z, degenerate,
			overflowed,
		output ready
	);
endinterface

// File: design/plane_projection_coefficients_top.sv
// top level of the plane projection coefficients block
// Takes one word per cycle holding spanning vectors A, B and a point P (signed fixed point)
// and returns the Cramer coefficients of A and B and the in-plane projection, rounded to
// nearest and saturated. The word passes stages of exact wide arithmetic on pipelined
// multipliers, then a divider that resolves one quotient bit per stage. Throughput is one
// word per cycle; the whole pipeline holds while a finished result waits and the output is
// not taken.
`include "plane_projection_coefficients_top_macros.svh"
module plane_projection_coefficients_top import ppc_pkg::*; #(
	parameter int DATA_WIDTH = PPC_DATA_WIDTH,
	parameter int FRAC_BITS  = PPC_FRAC_BITS
) (
	input logic          clk,
	input logic          arst_n,
	ppc_item_if.sink     item,
	ppc_result_if.source result
);
	localparam int W = DATA_WIDTH;
	localparam int NWID = 2 * W + 1;
	localparam int DENW = 4 * W + 4;
	localparam int CRW = 3 * W + 2;
	localparam int NUMW = 4 * W + 4;
	localparam int SUMW = 5 * W + 5;
	localparam int DIVN = ppc_max(SUMW, NUMW + FRAC_BITS);
	localparam int VL = W + 17;
	localparam int DEGL = W + 9;
	localparam logic [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};
	localparam logic [W-1:0] MAXV = ~MINV;

	logic en;
	logic vld_s [VL];
	logic signed [W-1:0] a_s [10][3];
	logic signed [W-1:0] b_s [10][3];
	logic signed [W-1:0] p_s [7][3];
	logic signed [2*W-1:0] ab_s3 [3];
	logic signed [2*W-1:0] ba_s3 [3];
	logic signed [NWID-1:0] n_s4 [3];
	logic signed [2*NWID-1:0] nn_s6 [3];
	logic signed [W+NWID-1:0] bn_s6 [3];
	logic signed [W+NWID-1:0] nb_s6 [3];
	logic signed [W+NWID-1:0] ne_s6 [3];
	logic signed [W+NWID-1:0] ek_s6 [3];
	logic [DENW-1:0] den_s [7];
	logic signed [CRW-1:0] c_s7 [3];
	logic signed [CRW-1:0] e_s7 [3];
	logic signed [CRW+W-1:0] cp_s9 [3];
	logic signed [CRW+W-1:0] ep_s9 [3];
	logic signed [NUMW-1:0] na_s [4];
	logic signed [NUMW-1:0] nb_s [4];
	logic signed [NUMW+W-1:0] pa_s12 [3];
	logic signed [NUMW+W-1:0] pb_s12 [3];
	logic signed [SUMW-1:0] pr_s13 [3];
	logic deg_s [DEGL];
	logic signed [W-1:0] dres [5];
	logic dovf [5];
	logic all_inner;

	assign en = !result.valid || result.ready;
	assign item.ready = en;
	assign result.valid = vld_s[VL-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < VL; k++) begin
				vld_s[k] <= 1'b0;
			end
		end else if (en) begin
			vld_s[0] <= item.valid;
			for (int k = 1; k < VL; k++) begin
				vld_s[k] <= vld_s[k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_s[0][0] <= item.first_x;
			a_s[0][1] <= item.first_y;
			a_s[0][2] <= item.first_z;
			b_s[0][0] <= item.second_x;
			b_s[0][1] <= item.second_y;
			b_s[0][2] <= item.second_z;
			p_s[0][0] <= item.point_x;
			p_s[0][1] <= item.point_y;
			p_s[0][2] <= item.point_z;
			for (int k = 1; k < 10; k++) begin
				a_s[k] <= a_s[k-1];
				b_s[k] <= b_s[k-1];
			end
			for (int k = 1; k < 7; k++) begin
				p_s[k] <= p_s[k-1];
				den_s[k] <= den_s[k-1];
			end
			for (int i = 0; i < 3; i++) begin
				n_s4[i] <= NWID'(ab_s3[i]) - NWID'(ba_s3[i]);
				c_s7[i] <= CRW'(bn_s6[i]) - CRW'(nb_s6[i]);
				e_s7[i] <= CRW'(ne_s6[i]) - CRW'(ek_s6[i]);
				pr_s13[i] <= SUMW'(pa_s12[i]) + SUMW'(pb_s12[i]);
			end
			den_s[0] <= DENW'(nn_s6[0]) + DENW'(nn_s6[1]) + DENW'(nn_s6[2]);
			na_s[0] <= NUMW'(cp_s9[0]) + NUMW'(cp_s9[1]) + NUMW'(cp_s9[2]);
			nb_s[0] <= NUMW'(ep_s9[0]) + NUMW'(ep_s9[1]) + NUMW'(ep_s9[2]);
			for (int k = 1; k < 4; k++) begin
				na_s[k] <= na_s[k-1];
				nb_s[k] <= nb_s[k-1];
			end
			deg_s[0] <= den_s[0] == '0;
			for (int k = 1; k < DEGL; k++) begin
				deg_s[k] <= deg_s[k-1];
			end
			result.degenerate <= deg_s[DEGL-1];
			result.overflowed <= !deg_s[DEGL-1] &&
				(dovf[0] || dovf[1] || dovf[2] || dovf[3] || dovf[4]);
			result.coef_first <= deg_s[DEGL-1] ? '0 : dres[0];
			result.coef_second <= deg_s[DEGL-1] ? '0 : dres[1];
			result.proj_x <= deg_s[DEGL-1] ? '0 : dres[2];
			result.proj_y <= deg_s[DEGL-1] ? '0 : dres[3];
			result.proj_z <= deg_s[DEGL-1] ? '0 : dres[4];
		end
	end

	for (genvar i = 0; i < 3; i++) begin : g_axis
		localparam int J = (i + 1) % 3;
		localparam int K = (i + 2) % 3;

		// normal
		ppc_mul #(.AW(W), .BW(W)) u_ab (
			.clk, .en, .a(a_s[0][J]), .b(b_s[0][K]), .p(ab_s3[i])
		);
		ppc_mul #(.AW(W), .BW(W)) u_ba (
			.clk, .en, .a(a_s[0][K]), .b(b_s[0][J]), .p(ba_s3[i])
		);

		// determinant terms, b x n and n x a
		ppc_mul #(.AW(NWID), .BW(NWID)) u_nn (
			.clk, .en, .a(n_s4[i]), .b(n_s4[i]), .p(nn_s6[i])
		);
		ppc_mul #(.AW(W), .BW(NWID)) u_bn (
			.clk, .en, .a(b_s[3][J]), .b(n_s4[K]), .p(bn_s6[i])
		);
		ppc_mul #(.AW(W), .BW(NWID)) u_nb (
			.clk, .en, .a(b_s[3][K]), .b(n_s4[J]), .p(nb_s6[i])
		);
		ppc_mul #(.AW(W), .BW(NWID)) u_ne (
			.clk, .en, .a(a_s[3][K]), .b(n_s4[J]), .p(ne_s6[i])
		);
		ppc_mul #(.AW(W), .BW(NWID)) u_ek (
			.clk, .en, .a(a_s[3][J]), .b(n_s4[K]), .p(ek_s6[i])
		);

		// numerators
		ppc_mul #(.AW(CRW), .BW(W)) u_cp (
			.clk, .en, .a(c_s7[i]), .b(p_s[6][i]), .p(cp_s9[i])
		);
		ppc_mul #(.AW(CRW), .BW(W)) u_ep (
			.clk, .en, .a(e_s7[i]), .b(p_s[6][i]), .p(ep_s9[i])
		);

		// projection numerators
		ppc_mul #(.AW(NUMW), .BW(W)) u_pa (
			.clk, .en, .a(na_s[0]), .b(a_s[9][i]), .p(pa_s12[i])
		);
		ppc_mul #(.AW(NUMW), .BW(W)) u_pb (
			.clk, .en, .a(nb_s[0]), .b(b_s[9][i]), .p(pb_s12[i])
		);

		ppc_div #(.W(W), .NW(DIVN), .DW(DENW)) u_div_proj (
			.clk, .en, .num(DIVN'(pr_s13[i])), .den(den_s[6]),
			.res(dres[2+i]), .ovf(dovf[2+i])
		);
	end

	ppc_div #(.W(W), .NW(DIVN), .DW(DENW)) u_div_first (
		.clk, .en, .num(DIVN'(na_s[3]) <<< FRAC_BITS), .den(den_s[6]),
		.res(dres[0]), .ovf(dovf[0])
	);
	ppc_div #(.W(W), .NW(DIVN), .DW(DENW)) u_div_second (
		.clk, .en, .num(DIVN'(nb_s[3]) <<< FRAC_BITS), .den(den_s[6]),
		.res(dres[1]), .ovf(dovf[1])
	);

	always_comb begin
		all_inner = result.coef_first != MINV && result.coef_first != MAXV &&
			result.coef_second != MINV && result.coef_second != MAXV &&
			result.proj_x != MINV && result.proj_x != MAXV &&
			result.proj_y != MINV && result.proj_y != MAXV &&
			result.proj_z != MINV && result.proj_z != MAXV;
	end

	`PPC_ASSERT_NOW(a_deg_zero, clk, arst_n, result.valid && result.degenerate, !result.overflowed && result.coef_first == '0 && result.proj_x == '0, "degenerate word not cleared")
	`PPC_ASSERT_NOW(a_ovf_bound, clk, arst_n, result.valid && all_inner, !result.overflowed, "overflow without a saturated field")
	`PPC_ASSERT_NEXT(a_stall_hold, clk, arst_n, vld_s[0] && !en, vld_s[0], "stage one word lost in stall")
endmodule

// File: design/ppc_mul.sv
// two-stage signed multiplier built from chunk partial products
module ppc_mul import ppc_pkg::*; #(
	parameter int AW = 32,
	parameter int BW = 32
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic signed [AW-1:0]     a,
	input  logic signed [BW-1:0]     b,
	output logic signed [AW+BW-1:0]  p
);
	localparam int CH = PPC_MUL_CHUNK;
	localparam int NA = (AW + CH - 1) / CH;
	localparam int NB = (BW + CH - 1) / CH;
	localparam int PW = (NA + NB) * CH;

	logic [AW-1:0] ua;
	logic [BW-1:0] ub;
	logic [NA*CH-1:0] ma;
	logic [NB*CH-1:0] mb;
	logic [2*CH-1:0] pp_s1 [NA][NB];
	logic neg_s1;
	logic [PW-1:0] sum;

	always_comb begin
		ua = a[AW-1] ? -a : a;
		ub = b[BW-1] ? -b : b;
		ma = (NA*CH)'(ua);
		mb = (NB*CH)'(ub);
		sum = '0;
		for (int i = 0; i < NA; i++) begin
			for (int j = 0; j < NB; j++) begin
				sum = sum + (PW'(pp_s1[i][j]) << ((i + j) * CH));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			neg_s1 <= a[AW-1] ^ b[BW-1];
			for (int i = 0; i < NA; i++) begin
				for (int j = 0; j < NB; j++) begin
					pp_s1[i][j] <= ma[i*CH +: CH] * mb[j*CH +: CH];
				end
			end
			p <= neg_s1 ? (AW+BW)'(-sum) : (AW+BW)'(sum);
		end
	end
endmodule

// File: design/ppc_div.sv
// pipelined rounding divider with saturation, one quotient bit per stage
module ppc_div import ppc_pkg::*; #(
	parameter int W  = 32,
	parameter int NW = 165,
	parameter int DW = 132
) (
	input  logic                 clk,
	input  logic                 en,
	input  logic signed [NW-1:0] num,
	input  logic [DW-1:0]        den,
	output logic signed [W-1:0]  res,
	output logic                 ovf
);
	localparam int XW = ppc_max(NW + 1, DW) + 1;
	localparam int CW = ppc_max(XW, DW + 1 + W);
	localparam logic [W-1:0] LIM = {1'b1, {(W-1){1'b0}}};

	logic [NW-1:0] mag;
	logic [XW-1:0] x_q;
	logic [DW:0] d2_q;
	logic neg_q;
	logic [XW-1:0] r_s [W];
	logic [DW:0] d2_s [W];
	logic neg_s [W+1];
	logic big_s [W+1];
	logic [W-1:0] q_s [W+1];
	logic [CW-1:0] sh [W];
	logic ge [W];
	logic [XW-1:0] rn [W];

	always_comb begin
		mag = num[NW-1] ? -num : num;
		for (int k = 0; k < W; k++) begin
			sh[k] = CW'(d2_s[k]) << (W - 1 - k);
			ge[k] = CW'(r_s[k]) >= sh[k];
			rn[k] = XW'(CW'(r_s[k]) - sh[k]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_q <= (XW'(mag) << 1) + XW'(den);
			d2_q <= {den, 1'b0};
			neg_q <= num[NW-1];
			r_s[0] <= x_q;
			d2_s[0] <= d2_q;
			neg_s[0] <= neg_q;
			big_s[0] <= CW'(x_q) >= (CW'(d2_q) << W);
			q_s[0] <= '0;
			for (int k = 0; k < W; k++) begin
				if (k < W - 1) begin
					r_s[k+1] <= ge[k] ? rn[k] : r_s[k];
					d2_s[k+1] <= d2_s[k];
				end
				neg_s[k+1] <= neg_s[k];
				big_s[k+1] <= big_s[k];
				q_s[k+1] <= {q_s[k][W-2:0], ge[k]};
			end
			if (big_s[W]) begin
				ovf <= 1'b1;
				res <= neg_s[W] ? LIM : ~LIM;
			end else if (neg_s[W]) begin
				ovf <= q_s[W] > LIM;
				res <= (q_s[W] > LIM) ? LIM : -q_s[W];
			end else begin
				ovf <= q_s[W] >= LIM;
				res <= (q_s[W] >= LIM) ? ~LIM : q_s[W];
			end
		end
	end
endmodule

// File: tb/plane_projection_coefficients_top_tb.sv
// testbench of the plane projection coefficients block against a wide-integer predictor
module plane_projection_coefficients_top_tb import ppc_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DW = PPC_DATA_WIDTH;
	localparam int FB = PPC_FRAC_BITS;
	localparam int CYCLE_LIMIT = 200000;
	localparam int SETTLE_CYCLES = DW + 40;
	localparam logic signed [DW-1:0] MAX_VAL = {1'b0, {(DW-1){1'b1}}};
	localparam logic signed [DW-1:0] MIN_VAL = {1'b1, {(DW-1){1'b0}}};
	localparam logic signed [DW-1:0] ONE = 1 <<< FB;

	typedef logic signed [255:0] wide_t;

	typedef struct {
		logic signed [DW-1:0] ax, ay, az, bx, by, bz, px, py, pz;
	} geom_t;

	typedef struct {
		logic signed [DW-1:0] coef_first, coef_second, proj_x, proj_y, proj_z;
		logic degenerate, overflowed;
	} plane_coef_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int cycle_count = 0;
	int mismatches = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	bit hold_output = 1'b0;
	plane_coef_t pending_coefs[$];

	ppc_item_if item_ch ();
	ppc_result_if result_ch ();

	plane_projection_coefficients_top u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.item(item_ch),
		.result(result_ch)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("plane_projection_coefficients_top_tb: FAIL");
			$finish;
		end
	end

	// rounds num/den to nearest, ties away from zero, then clamps to the word range
	function automatic logic signed [DW-1:0] round_clamp(input wide_t num, input wide_t den,
			inout logic ovf);
		wide_t mag, quo, lim;
		logic neg;
		neg = num < 0;
		mag = neg ? -num : num;
		lim = wide_t'(1) <<< (DW - 1);
		quo = (2 * mag + den) / (2 * den);
		if (neg) begin
			if (quo > lim) begin
				ovf = 1'b1;
				return MIN_VAL;
			end
			return -quo[DW-1:0];
		end
		if (quo >= lim) begin
			ovf = 1'b1;
			return MAX_VAL;
		end
		return quo[DW-1:0];
	endfunction

	function automatic plane_coef_t predict_coefs(input geom_t g);
		wide_t a0, a1, a2, b0, b1, b2, p0, p1, p2, n0, n1, n2;
		wide_t c0, c1, c2, e0, e1, e2, den, num_a, num_b;
		plane_coef_t r;
		logic ovf;
		a0 = g.ax; a1 = g.ay; a2 = g.az;
		b0 = g.bx; b1 = g.by; b2 = g.bz;
		p0 = g.px; p1 = g.py; p2 = g.pz;
		n0 = a1 * b2 - a2 * b1;
		n1 = a2 * b0 - a0 * b2;
		n2 = a0 * b1 - a1 * b0;
		den = n0 * n0 + n1 * n1 + n2 * n2;
		r = '{default: '0};
		if (den == 0) begin
			r.degenerate = 1'b1;
			return r;
		end
		c0 = b1 * n2 - b2 * n1;
		c1 = b2 * n0 - b0 * n2;
		c2 = b0 * n1 - b1 * n0;
		e0 = n1 * a2 - n2 * a1;
		e1 = n2 * a0 - n0 * a2;
		e2 = n0 * a1 - n1 * a0;
		num_a = c0 * p0 + c1 * p1 + c2 * p2;
		num_b = e0 * p0 + e1 * p1 + e2 * p2;
		ovf = 1'b0;
		r.coef_first = round_clamp(num_a <<< FB, den, ovf);
		r.coef_second = round_clamp(num_b <<< FB, den, ovf);
		r.proj_x = round_clamp(num_a * a0 + num_b * b0, den, ovf);
		r.proj_y = round_clamp(num_a * a1 + num_b * b1, den, ovf);
		r.proj_z = round_clamp(num_a * a2 + num_b * b2, den, ovf);
		r.overflowed = ovf;
		return r;
	endfunction

	function automatic geom_t mk(input logic signed [DW-1:0] ax, ay, az, bx, by, bz,
			px, py, pz);
		geom_t g;
		g = '{ax, ay, az, bx, by, bz, px, py, pz};
		return g;
	endfunction

	task automatic send_word(input geom_t g);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			item_ch.valid <= 1'b0;
			@(posedge clk);
		end
		item_ch.valid <= 1'b1;
		item_ch.first_x <= g.ax;
		item_ch.first_y <= g.ay;
		item_ch.first_z <= g.az;
		item_ch.second_x <= g.bx;
		item_ch.second_y <= g.by;
		item_ch.second_z <= g.bz;
		item_ch.point_x <= g.px;
		item_ch.point_y <= g.py;
		item_ch.point_z <= g.pz;
		@(posedge clk);
		while (!item_ch.ready)
			@(posedge clk);
		pending_coefs.push_back(predict_coefs(g));
	endtask

	task automatic wait_drained();
		item_ch.valid <= 1'b0;
		while (pending_coefs.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	always @(posedge clk) begin
		if (!arst_n)
			result_ch.ready <= 1'b0;
		else
			result_ch.ready <= !hold_output && ($urandom_range(0, 99) >= recv_idle_pct);
	end

	task automatic report_mismatch(input string what, input logic signed [DW-1:0] got,
			input logic signed [DW-1:0] want);
		$display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want,
			cycle_count);
		mismatches++;
	endtask

	always @(posedge clk) begin
		plane_coef_t want;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (pending_coefs.size() == 0) begin
				report_mismatch("unexpected word", 0, 0);
			end else begin
				want = pending_coefs.pop_front();
				if (result_ch.coef_first !== want.coef_first)
					report_mismatch("coef_first", result_ch.coef_first, want.coef_first);
				if (result_ch.coef_second !== want.coef_second)
					report_mismatch("coef_second", result_ch.coef_second, want.coef_second);
				if (result_ch.proj_x !== want.proj_x)
					report_mismatch("proj_x", result_ch.proj_x, want.proj_x);
				if (result_ch.proj_y !== want.proj_y)
					report_mismatch("proj_y", result_ch.proj_y, want.proj_y);
				if (result_ch.proj_z !== want.proj_z)
					report_mismatch("proj_z", result_ch.proj_z, want.proj_z);
				if (result_ch.degenerate !== want.degenerate)
					report_mismatch("degenerate", DW'(result_ch.degenerate),
						DW'(want.degenerate));
				if (result_ch.overflowed !== want.overflowed)
					report_mismatch("overflowed", DW'(result_ch.overflowed),
						DW'(want.overflowed));
			end
		end
	end

	function automatic logic signed [DW-1:0] rand_coord();
		case ($urandom_range(0, 4))
			0: return $urandom;
			1: return $signed(DW'($urandom)) >>> $urandom_range(0, DW - 1);
			2: return $signed(DW'($urandom_range(0, 8 * ONE))) - 4 * ONE;
			3: begin
				case ($urandom_range(0, 4))
					0: return MAX_VAL;
					1: return MIN_VAL;
					2: return 0;
					3: return 1;
					default: return -1;
				endcase
			end
			default: return $signed(DW'($urandom_range(0, 2 * ONE))) - ONE;
		endcase
	endfunction

	function automatic geom_t rand_geom();
		geom_t g;
		int k;
		g = mk(rand_coord(), rand_coord(), rand_coord(), rand_coord(), rand_coord(),
			rand_coord(), rand_coord(), rand_coord(), rand_coord());
		// parallel spanning vectors now and then
		if ($urandom_range(0, 9) == 0) begin
			k = $urandom_range(0, 6) - 3;
			g.ax = g.ax >>> 8;
			g.ay = g.ay >>> 8;
			g.az = g.az >>> 8;
			g.bx = g.ax * k;
			g.by = g.ay * k;
			g.bz = g.az * k;
		end
		return g;
	endfunction

	task automatic test_directed();
		send_word(mk(0, 0, 0, 0, 0, 0, 0, 0, 0));
		send_word(mk(ONE, 0, 0, 0, ONE, 0, 3 * ONE, 4 * ONE, 5 * ONE));
		send_word(mk(ONE, 2 * ONE, 3 * ONE, 2 * ONE, 4 * ONE, 6 * ONE, ONE, ONE, ONE));
		send_word(mk(0, 0, 0, ONE, 2 * ONE, -ONE, ONE, ONE, ONE));
		send_word(mk(ONE, 2 * ONE, 3 * ONE, 0, 0, 0, ONE, ONE, ONE));
		send_word(mk(MAX_VAL, MAX_VAL, MAX_VAL, MIN_VAL, MIN_VAL, MIN_VAL,
			MAX_VAL, MIN_VAL, MAX_VAL));
		send_word(mk(MIN_VAL, 0, 0, 0, MIN_VAL, 0, MAX_VAL, MAX_VAL, MAX_VAL));
		send_word(mk(MAX_VAL, 0, 0, 0, 0, MIN_VAL, MIN_VAL, MIN_VAL, MIN_VAL));
		send_word(mk(1, 0, 0, 0, 1, 0, MAX_VAL, MIN_VAL, 0));
		// half-lsb ties, both signs
		send_word(mk(2 * ONE, 0, 0, 0, 2 * ONE, 0, 1, -1, 0));
		send_word(mk(2 * ONE, 0, 0, 0, 2 * ONE, 0, 3, -3, 7));
		send_word(mk(ONE, ONE, 0, -ONE, ONE, 0, 5 * ONE, -7 * ONE, 9 * ONE));
		send_word(mk('h55555555, 'haaaaaaaa, 'h55555555, 'haaaaaaaa, 'h55555555,
			'haaaaaaaa, 'h55555555, 'haaaaaaaa, 'h55555555));
		send_word(mk(ONE + 3, 2 * ONE - 5, -ONE / 3, ONE / 7, -3 * ONE, ONE + 11,
			-1, 1, ONE));
		send_word(mk(-1, -1, -1, 1, -1, 1, -1, -1, -1));
		send_word(mk(ONE, 0, 0, ONE, 1, 0, 0, MAX_VAL, 0));
		wait_drained();
	endtask

	task automatic test_random(input int count, input int s_idle, input int r_idle);
		send_idle_pct = s_idle;
		recv_idle_pct = r_idle;
		repeat (count) send_word(rand_geom());
		wait_drained();
	endtask

	task automatic test_backpressure();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		fork
			begin
				hold_output <= 1'b1;
				repeat (200) @(posedge clk);
				hold_output <= 1'b0;
			end
			repeat (100) send_word(rand_geom());
		join
		wait_drained();
	endtask

	initial begin
		item_ch.valid = 1'b0;
		item_ch.first_x = '0;
		item_ch.first_y = '0;
		item_ch.first_z = '0;
		item_ch.second_x = '0;
		item_ch.second_y = '0;
		item_ch.second_z = '0;
		item_ch.point_x = '0;
		item_ch.point_y = '0;
		item_ch.point_z = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(112, 36, 85);
		test_random(112, 85, 36);
		test_random(112, 0, 0);
		test_backpressure();
		if (mismatches == 0) begin
			$display("plane_projection_coefficients_top_tb: PASS");
		end else begin
			$display("plane_projection_coefficients_top_tb: FAIL");
		end
		$finish;
	end
endmodule

// File: files.f
+incdir+design
design/ppc_pkg.sv
design/ppc_item_if.sv
design/ppc_result_if.sv
design/ppc_mul.sv
design/ppc_div.sv
design/plane_projection_coefficients_top.sv
tb/plane_projection_coefficients_top_tb.sv
